// ----- src/tgr_pkg.sv -----
package tgr_pkg;

    // Default geometry of the font and glyph cell.
    localparam int GLYPH_ROWS_DEF = 16;
    localparam int GLYPH_COLS_DEF = 12;
    localparam int FONT_WORDS_DEF = 4096;

    // Field widths of the input and result items.
    localparam int FUNC_W      = 2;
    localparam int FONT_ADDR_W = 12;
    localparam int FONT_WORD_W = 16;
    localparam int TEXT_ROW_W  = 4;
    localparam int TEXT_COL_W  = 5;
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 16;
    localparam int PIX_X_W     = 16;
    localparam int PIX_Y_W     = 8;
    localparam int MASK_W      = 12;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;

    // Cursor placement for a start item: y = row*24 - 19, x = col*12 - 7.
    localparam int START_Y_STEP = 24;
    localparam int START_Y_OFS  = 19;
    localparam int START_X_STEP = 12;
    localparam int START_X_OFS  = 7;

    // Font words between consecutive glyph rows of one character.
    localparam int ROW_STRIDE = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_DRAW  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic font_wr;
        logic cursor_set;
        logic draw_start;
        logic rd_en;
        logic row_next;
        logic draw_end;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_row;
    } t_sts;

endpackage

// ----- src/tgr_ctrl.sv -----
module tgr_ctrl
    import tgr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_func i_func,
    input  logic  i_out_ready,
    input  t_sts  i_sts,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_acc;
    logic   out_acc;

    assign in_acc  = (r_state == ST_IDLE) && i_in_valid;
    assign out_acc = (r_state == ST_EMIT) && i_out_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a draw item reads its first row, then emits one row per item taken.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_func == FUNC_DRAW)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_acc && i_sts.last_row) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_EMIT);
        if (in_acc) begin
            unique case (i_func)
                FUNC_LOAD:  o_cmd.font_wr    = 1'b1;
                FUNC_START: o_cmd.cursor_set = 1'b1;
                FUNC_DRAW:  o_cmd.draw_start = 1'b1;
                default:    o_cmd.font_wr    = 1'b0;
            endcase
        end
        if (r_state == ST_READ) begin
            o_cmd.rd_en = 1'b1;
        end
        if (out_acc) begin
            o_cmd.row_next = 1'b1;
            if (i_sts.last_row) begin
                o_cmd.draw_end = 1'b1;
            end else begin
                o_cmd.rd_en = 1'b1;
            end
        end
    end

endmodule

// ----- src/tgr_dpath.sv -----
module tgr_dpath
    import tgr_pkg::*;
#(
    parameter int GLYPH_ROWS = GLYPH_ROWS_DEF,
    parameter int GLYPH_COLS = GLYPH_COLS_DEF,
    parameter int FONT_WORDS = FONT_WORDS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [FONT_ADDR_W-1:0] i_font_addr,
    input  logic [FONT_WORD_W-1:0] i_font_word,
    input  logic [TEXT_ROW_W-1:0]  i_text_row,
    input  logic [TEXT_COL_W-1:0]  i_text_col,
    input  logic [CHAR_W-1:0]      i_char_code,
    input  logic [COLOR_W-1:0]     i_back_color,
    output t_sts                   o_sts,
    output logic [PIX_X_W-1:0]     o_pixel_x,
    output logic [PIX_Y_W-1:0]     o_pixel_y,
    output logic [MASK_W-1:0]      o_fore_mask,
    output logic [COLOR_W-1:0]     o_span_color
);

    localparam int ADDR_W = $clog2(FONT_WORDS);
    localparam int ROW_W  = $clog2(GLYPH_ROWS);
    localparam int LIN_W  = FONT_ADDR_W + 1;
    localparam logic [LIN_W-1:0] FW_L        = LIN_W'(FONT_WORDS);
    localparam logic [LIN_W-1:0] CODE_STRIDE = LIN_W'(GLYPH_ROWS * ROW_STRIDE);
    localparam logic [LIN_W-1:0] ROW_STEP    = LIN_W'(ROW_STRIDE);

    // Reduce a linear word address into the font memory; it never exceeds 4*FONT_WORDS.
    function automatic logic [LIN_W-1:0] fold(input logic [LIN_W-1:0] v);
        logic [LIN_W-1:0] t;
        t = v;
        for (int i = 0; i < 4; i++) begin
            if (t >= FW_L) begin
                t = t - FW_L;
            end
        end
        return t;
    endfunction

    logic [FONT_WORD_W-1:0] font_mem [FONT_WORDS];

    logic [FONT_WORD_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]      r_addr;
    logic [ROW_W-1:0]       r_row;
    logic [PIX_Y_W-1:0]     r_pix_y;
    logic [COLOR_W-1:0]     r_color;
    logic [PIX_X_W-1:0]     r_cursor_x;
    logic [PIX_Y_W-1:0]     r_cursor_y;
    logic [PIX_X_W-1:0]     n_cursor_x;
    logic [PIX_Y_W-1:0]     n_cursor_y;
    logic [LIN_W-1:0]       base_addr;
    logic [MASK_W-1:0]      mask;
    logic                   load_ok;

    // Font memory: one write port for load items, one registered read port for rows.
    assign load_ok = (LIN_W'(i_font_addr) < FW_L);

    always_ff @(posedge i_clk) begin
        if (i_cmd.font_wr && load_ok) begin
            font_mem[i_font_addr[ADDR_W-1:0]] <= i_font_word;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= font_mem[r_addr];
        end
    end

    // First glyph row address of a character: code column plus code row times glyph height times the row stride.
    assign base_addr = LIN_W'(i_char_code[CHAR_W-1:4]) * CODE_STRIDE
                     + LIN_W'(i_char_code[3:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.draw_start) begin
            r_addr <= ADDR_W'(fold(base_addr));
        end else if (i_cmd.rd_en) begin
            r_addr <= ADDR_W'(fold(LIN_W'(r_addr) + ROW_STEP));
        end
    end

    // Row counter of the glyph being drawn.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_cmd.draw_start) begin
            r_row <= '0;
        end else if (i_cmd.row_next) begin
            r_row <= r_row + ROW_W'(1);
        end
    end

    // Span payload: the colour is held for the whole draw, the row y steps by one with each span taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.draw_start) begin
            r_pix_y <= r_cursor_y;
            r_color <= i_back_color;
        end else if (i_cmd.row_next) begin
            r_pix_y <= r_pix_y + PIX_Y_W'(1);
        end
    end

    // Cursor placement for a start item.
    assign n_cursor_y = PIX_Y_W'(i_text_row) * PIX_Y_W'(START_Y_STEP)
                      - PIX_Y_W'(START_Y_OFS);
    assign n_cursor_x = PIX_X_W'(i_text_col) * PIX_X_W'(START_X_STEP)
                      - PIX_X_W'(START_X_OFS);

    // Cursor: set by a start item, stepped by one cell after each draw.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_cursor_y <= '0;
        end else if (i_cmd.cursor_set) begin
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
        end else if (i_cmd.draw_end) begin
            r_cursor_x <= r_cursor_x + PIX_X_W'(GLYPH_COLS);
        end
    end

    // Mask column k takes word bit 16-k; column 0 and columns past the cell stay clear.
    for (genvar k = 0; k < MASK_W; k++) begin : g_mask
        if ((k >= 1) && (k < GLYPH_COLS)) begin : g_bit
            assign mask[k] = r_rd_data[FONT_WORD_W-k];
        end else begin : g_clear
            assign mask[k] = 1'b0;
        end
    end

    assign o_sts.last_row = (r_row == ROW_W'(GLYPH_ROWS - 1));
    assign o_pixel_x      = r_cursor_x;
    assign o_pixel_y      = r_pix_y;
    assign o_fore_mask    = mask;
    assign o_span_color   = r_color;

endmodule

// ----- src/text_glyph_rasterizer.sv -----
// Load and start items leave the block idle; the next item is accepted in the following cycle.
// A draw item gives GLYPH_ROWS spans: the first is offered after the read state fetches its
// glyph row, then one span per cycle while the sink is ready, as the single font memory
// read port delivers one glyph row per cycle. Reset (synchronous, active low) clears the
// controller and the cursor to zero; the font memory keeps its contents and holds no
// defined value until written.
module text_glyph_rasterizer
    import tgr_pkg::*;
#(
    parameter int GLYPH_ROWS = GLYPH_ROWS_DEF,
    parameter int GLYPH_COLS = GLYPH_COLS_DEF,
    parameter int FONT_WORDS = FONT_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // font_addr[11:0], font_word[27:12], text_row[31:28], text_col[36:32],
    // char_code[44:37], back_color[60:45], zero[63:61]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]    s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // pixel_x[15:0], pixel_y[23:16], fore_mask[35:24], span_color[51:36], zero[55:52]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // last_row
    output logic                 m_axis_tlast
);

    localparam int FONT_ADDR_LSB = 0;
    localparam int FONT_WORD_LSB = FONT_ADDR_LSB + FONT_ADDR_W;
    localparam int TEXT_ROW_LSB  = FONT_WORD_LSB + FONT_WORD_W;
    localparam int TEXT_COL_LSB  = TEXT_ROW_LSB + TEXT_ROW_W;
    localparam int CHAR_LSB      = TEXT_COL_LSB + TEXT_COL_W;
    localparam int COLOR_LSB     = CHAR_LSB + CHAR_W;

    t_cmd                 cmd;
    t_sts                 sts;
    logic [PIX_X_W-1:0]   pixel_x;
    logic [PIX_Y_W-1:0]   pixel_y;
    logic [MASK_W-1:0]    fore_mask;
    logic [COLOR_W-1:0]   span_color;

    // Sequencing of items and glyph rows.
    tgr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_func      (t_func'(s_axis_tuser)),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // Font memory, cursor and span registers.
    tgr_dpath #(
        .GLYPH_ROWS (GLYPH_ROWS),
        .GLYPH_COLS (GLYPH_COLS),
        .FONT_WORDS (FONT_WORDS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_font_addr  (s_axis_tdata[FONT_ADDR_LSB +: FONT_ADDR_W]),
        .i_font_word  (s_axis_tdata[FONT_WORD_LSB +: FONT_WORD_W]),
        .i_text_row   (s_axis_tdata[TEXT_ROW_LSB +: TEXT_ROW_W]),
        .i_text_col   (s_axis_tdata[TEXT_COL_LSB +: TEXT_COL_W]),
        .i_char_code  (s_axis_tdata[CHAR_LSB +: CHAR_W]),
        .i_back_color (s_axis_tdata[COLOR_LSB +: COLOR_W]),
        .o_sts        (sts),
        .o_pixel_x    (pixel_x),
        .o_pixel_y    (pixel_y),
        .o_fore_mask  (fore_mask),
        .o_span_color (span_color)
    );

    // Pack the span item.
    assign m_axis_tdata = M_TDATA_W'({span_color, fore_mask, pixel_y, pixel_x});
    assign m_axis_tlast = sts.last_row;

endmodule

// ----- src/tgr_checker.sv -----
module tgr_checker
    import tgr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [FUNC_W-1:0]    s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);

    // A stalled span item holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("span item changed while stalled");

    // The block takes no item while it still offers spans.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while spans pending");

    // After a draw item the block turns busy and offers no span in the next cycle.
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_DRAW)
            |=> !s_axis_tready && !m_axis_tvalid)
        else $error("draw item did not start a glyph");

    // Items other than draw leave the block idle and produce nothing.
    a_no_draw_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != FUNC_DRAW)
            |=> s_axis_tready && !m_axis_tvalid)
        else $error("non-draw item produced output or stalled");

    // The last glyph row ends the draw and frees the input.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
        else $error("block did not return to idle after last row");

endmodule

bind text_glyph_rasterizer tgr_checker u_tgr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
